[rtl/constrained_int_pair_map_defines.svh]
// ---------------------------------------------------------------------------
// constrained_int_pair_map assertion macros
// Concurrent check wrappers; they collapse to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef CONSTRAINED_INT_PAIR_MAP_DEFINES_SVH
`define CONSTRAINED_INT_PAIR_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: ante holds -> cons holds on this edge
`define CIPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: ante holds -> cons holds on the following edge
`define CIPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CIPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CIPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/cipm_pkg.sv]
// ---------------------------------------------------------------------------
// cipm_pkg
// Shared types and constants of the integer pair map.
// ---------------------------------------------------------------------------
package cipm_pkg;

   // Table capacity and derived widths
   localparam int MAP_ENTRIES = 256;
   localparam int ADDR_W      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

   // Fixed field widths
   localparam int VALUE_W       = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 3;
   localparam int INDEX_W       = 8;
   localparam int ENTRY_COUNT_W = 9;

   // Stream payload widths
   localparam int REQ_TDATA_W = 3 * VALUE_W + INDEX_W;
   localparam int RSP_FIELD_W = 2 * VALUE_W + STATUS_W + ENTRY_COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP   = 3'd0,
      KIND_INVERSE  = 3'd1,
      KIND_ADD      = 3'd2,
      KIND_CONFLICT = 3'd3,
      KIND_UPDATE   = 3'd4,
      KIND_CLEAR    = 3'd5,
      KIND_READ     = 3'd6
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_PRESENT     = 3'd1,
      ST_CONFLICT    = 3'd2,
      ST_NOTFOUND    = 3'd3,
      ST_FULL        = 3'd4,
      ST_RANGE       = 3'd5,
      ST_UNSUPPORTED = 3'd6
   } status_type;

   // Map mode register values
   localparam logic MODE_ONE_TO_ONE = 1'b0;

   // One incoming item
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] key_from;
      logic signed [VALUE_W-1:0] key_to;
      logic signed [VALUE_W-1:0] fail_value;
      logic [INDEX_W-1:0]        entry_index;
   } req_type;

   // One result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] out_from;
      logic signed [VALUE_W-1:0] out_to;
      status_type                status;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } rsp_type;

   // Pair memory access, one read and one write port
   typedef struct packed {
      logic                      rd_en;
      logic [ADDR_W-1:0]         rd_addr;
      logic                      wr_en;
      logic [ADDR_W-1:0]         wr_addr;
      logic signed [VALUE_W-1:0] wr_from;
      logic signed [VALUE_W-1:0] wr_to;
   } ram_cmd_type;

endpackage

[rtl/cipm_pair_ram.sv]
// ---------------------------------------------------------------------------
// cipm_pair_ram
// Pair storage: from and to columns side by side, registered read.
// ---------------------------------------------------------------------------
module cipm_pair_ram (
   input  logic                              clock,
   input  cipm_pkg::ram_cmd_type             cmd,
   output logic signed [cipm_pkg::VALUE_W-1:0] rd_from,
   output logic signed [cipm_pkg::VALUE_W-1:0] rd_to
);

   logic [2*cipm_pkg::VALUE_W-1:0] mem [cipm_pkg::MAP_ENTRIES];
   logic [2*cipm_pkg::VALUE_W-1:0] rd_data_ff;

   // Write one pair, read one pair a cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= {cmd.wr_to, cmd.wr_from};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_from = rd_data_ff[cipm_pkg::VALUE_W-1:0];
   assign rd_to   = rd_data_ff[2*cipm_pkg::VALUE_W-1:cipm_pkg::VALUE_W];

endmodule

[rtl/cipm_seq.sv]
// ---------------------------------------------------------------------------
// cipm_seq
// Operation sequencer: scans the pair memory in order and commits updates.
// ---------------------------------------------------------------------------
`include "constrained_int_pair_map_defines.svh"

module cipm_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               map_mode,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cipm_pkg::req_type                  req,
   output logic                               res_valid,
   input  logic                               res_ready,
   output cipm_pkg::rsp_type                  res,
   output cipm_pkg::ram_cmd_type              ram_cmd,
   input  logic signed [cipm_pkg::VALUE_W-1:0] rd_from,
   input  logic signed [cipm_pkg::VALUE_W-1:0] rd_to
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD_WAIT,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                           state_ff, state_in;
   cipm_pkg::kind_type                  kind_ff, kind_in;
   logic signed [cipm_pkg::VALUE_W-1:0] kf_ff, kf_in;
   logic signed [cipm_pkg::VALUE_W-1:0] kt_ff, kt_in;
   logic signed [cipm_pkg::VALUE_W-1:0] fv_ff, fv_in;
   logic [cipm_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [cipm_pkg::CNT_W-1:0]          issue_ff, issue_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic [cipm_pkg::ADDR_W-1:0]         rd_pos_ff, rd_pos_in;
   cipm_pkg::rsp_type                   res_ff, res_in;

   logic same_from;
   logic same_to;
   logic exact;
   logic clash;
   logic hit;
   logic hit_now;
   logic scan_end;
   logic scan_rd;
   logic room;

   // Compare the pair read back last cycle against the keys
   always_comb begin
      same_from = (rd_from == kf_ff);
      same_to   = (rd_to == kt_ff);
      exact     = same_from && same_to;
      clash     = same_from || ((map_mode == cipm_pkg::MODE_ONE_TO_ONE) && same_to);
      case (kind_ff)
         cipm_pkg::KIND_LOOKUP:   hit = same_from;
         cipm_pkg::KIND_INVERSE:  hit = same_to;
         cipm_pkg::KIND_CONFLICT: hit = clash && !exact;
         cipm_pkg::KIND_ADD,
         cipm_pkg::KIND_UPDATE:   hit = clash;
         default:                 hit = 1'b0;
      endcase
      hit_now  = rd_vld_ff && hit;
      scan_rd  = (state_ff == S_SCAN) && (issue_ff < count_ff);
      scan_end = !rd_vld_ff && (issue_ff == count_ff);
      room     = (32'(count_ff) < cipm_pkg::MAP_ENTRIES);
   end

   // Next state, memory commands and result
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      kf_in     = kf_ff;
      kt_in     = kt_ff;
      fv_in     = fv_ff;
      count_in  = count_ff;
      issue_in  = issue_ff;
      res_in    = res_ff;
      rd_vld_in = scan_rd && !hit_now;
      rd_pos_in = cipm_pkg::ADDR_W'(issue_ff);

      ram_cmd         = '0;
      ram_cmd.rd_en   = scan_rd;
      ram_cmd.rd_addr = cipm_pkg::ADDR_W'(issue_ff);
      ram_cmd.wr_from = kf_ff;
      ram_cmd.wr_to   = kt_ff;

      if (scan_rd) begin
         issue_in = issue_ff + 1'b1;
      end

      case (state_ff)
         // Take an item and dispatch it
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = cipm_pkg::kind_type'(req.kind);
               kf_in    = req.key_from;
               kt_in    = req.key_to;
               fv_in    = req.fail_value;
               issue_in = '0;
               res_in.out_from = '0;
               res_in.out_to   = '0;
               res_in.status   = cipm_pkg::ST_OK;
               state_in = S_SCAN;
               case (req.kind)
                  cipm_pkg::KIND_LOOKUP,
                  cipm_pkg::KIND_INVERSE,
                  cipm_pkg::KIND_ADD,
                  cipm_pkg::KIND_CONFLICT: begin
                     state_in = S_SCAN;
                  end
                  cipm_pkg::KIND_UPDATE: begin
                     if (map_mode != cipm_pkg::MODE_ONE_TO_ONE) begin
                        res_in.status = cipm_pkg::ST_UNSUPPORTED;
                        state_in      = S_FINISH;
                     end
                  end
                  cipm_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     state_in = S_FINISH;
                  end
                  cipm_pkg::KIND_READ: begin
                     if (32'(req.entry_index) < 32'(count_ff)) begin
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = cipm_pkg::ADDR_W'(req.entry_index);
                        state_in        = S_RD_WAIT;
                     end else begin
                        res_in.out_from = req.fail_value;
                        res_in.out_to   = req.fail_value;
                        res_in.status   = cipm_pkg::ST_RANGE;
                        state_in        = S_FINISH;
                     end
                  end
                  default: begin
                     res_in.status = cipm_pkg::ST_UNSUPPORTED;
                     state_in      = S_FINISH;
                  end
               endcase
            end
         end

         // Read entry data arrives
         S_RD_WAIT: begin
            res_in.out_from = rd_from;
            res_in.out_to   = rd_to;
            state_in        = S_FINISH;
         end

         // Walk the stored pairs, first decisive match wins
         S_SCAN: begin
            if (hit_now) begin
               state_in = S_FINISH;
               case (kind_ff)
                  cipm_pkg::KIND_LOOKUP:   res_in.out_to   = rd_to;
                  cipm_pkg::KIND_INVERSE:  res_in.out_from = rd_from;
                  cipm_pkg::KIND_ADD: begin
                     res_in.status = exact ? cipm_pkg::ST_PRESENT : cipm_pkg::ST_CONFLICT;
                  end
                  cipm_pkg::KIND_CONFLICT: res_in.status   = cipm_pkg::ST_CONFLICT;
                  cipm_pkg::KIND_UPDATE: begin
                     if (exact) begin
                        res_in.status = cipm_pkg::ST_PRESENT;
                     end else begin
                        // overwrite the pair that shares from or to
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = rd_pos_ff;
                     end
                  end
                  default: res_in.status = cipm_pkg::ST_UNSUPPORTED;
               endcase
            end else if (scan_end) begin
               state_in = S_FINISH;
               case (kind_ff)
                  cipm_pkg::KIND_LOOKUP: begin
                     res_in.out_to = fv_ff;
                     res_in.status = cipm_pkg::ST_NOTFOUND;
                  end
                  cipm_pkg::KIND_INVERSE: begin
                     res_in.out_from = fv_ff;
                     res_in.status   = cipm_pkg::ST_NOTFOUND;
                  end
                  cipm_pkg::KIND_CONFLICT: res_in.status = cipm_pkg::ST_OK;
                  cipm_pkg::KIND_ADD,
                  cipm_pkg::KIND_UPDATE: begin
                     if (room) begin
                        // append behind the last pair
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = cipm_pkg::ADDR_W'(count_ff);
                        count_in        = count_ff + 1'b1;
                     end else begin
                        res_in.status = cipm_pkg::ST_FULL;
                     end
                  end
                  default: res_in.status = cipm_pkg::ST_UNSUPPORTED;
               endcase
            end
         end

         // Hand the result over
         S_FINISH: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      res_in.entry_count = cipm_pkg::ENTRY_COUNT_W'(count_in);
   end

   // Hold state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         issue_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         issue_ff  <= issue_in;
      end
      kind_ff   <= kind_in;
      kf_ff     <= kf_in;
      kt_ff     <= kt_in;
      fv_ff     <= fv_in;
      rd_pos_ff <= rd_pos_in;
      res_ff    <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FINISH);
   assign res       = res_ff;

   // Checks
   `CIPM_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= cipm_pkg::MAP_ENTRIES, "pair count above capacity")
   `CIPM_ASSERT_IMPLY(a_scan_in_range, clock, reset, rd_vld_ff, 32'(rd_pos_ff) < 32'(count_ff), "scan read beyond stored pairs")
   `CIPM_ASSERT_NEXT(a_write_then_finish, clock, reset, ram_cmd.wr_en, state_ff == S_FINISH, "pair write outside operation end")
   `CIPM_ASSERT_NEXT(a_count_step, clock, reset, 1'b1, count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1 || count_ff == '0, "pair count jumped")

endmodule

[rtl/constrained_int_pair_map.sv]
// ---------------------------------------------------------------------------
// constrained_int_pair_map
// Insertion-ordered table of (from, to) integer pairs with lookups and edits.
// ---------------------------------------------------------------------------
// One item is worked on at a time. Lookup, inverse lookup, add, conflict
// check and update walk the stored pairs in order through the single read
// port of the pair memory, one pair per cycle, and stop early when a pair
// decides the result. Read entry reads one pair through a read wait state;
// clear, an out-of-range read and unsupported operations need no memory
// read. The output register lets a finished result wait while the next
// item is accepted. Memory contents need no clearing after reset: only
// entries below the pair count are ever read.
// ---------------------------------------------------------------------------
module constrained_int_pair_map (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data,   // map_mode
   // Request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // key_from[31:0], key_to[63:32], fail_value[95:64], entry_index[103:96]
   input  logic [cipm_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic [cipm_pkg::KIND_W-1:0]           req_tuser,     // kind
   // Result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_from[31:0], out_to[63:32], status[66:64], entry_count[75:67], zero pad
   output logic [cipm_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   logic                                map_mode_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [cipm_pkg::RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   cipm_pkg::req_type                   req;
   cipm_pkg::rsp_type                   res;
   cipm_pkg::ram_cmd_type               ram_cmd;
   logic signed [cipm_pkg::VALUE_W-1:0] rd_from;
   logic signed [cipm_pkg::VALUE_W-1:0] rd_to;
   logic                                res_valid;
   logic                                res_ready;

   // Unpack the request item
   always_comb begin
      req.kind        = req_tuser;
      req.key_from    = req_tdata[cipm_pkg::VALUE_W-1:0];
      req.key_to      = req_tdata[2*cipm_pkg::VALUE_W-1:cipm_pkg::VALUE_W];
      req.fail_value  = req_tdata[3*cipm_pkg::VALUE_W-1:2*cipm_pkg::VALUE_W];
      req.entry_index = req_tdata[cipm_pkg::REQ_TDATA_W-1:3*cipm_pkg::VALUE_W];
   end

   cipm_pair_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_from (rd_from),
      .rd_to   (rd_to)
   );

   cipm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .map_mode  (map_mode_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_cmd   (ram_cmd),
      .rd_from   (rd_from),
      .rd_to     (rd_to)
   );

   // Load the output register when it is empty or draining
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{cipm_pkg::RSP_PAD_W{1'b0}}, res.entry_count, res.status,
                         res.out_to, res.out_from};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold mode register and output item
   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff  <= cipm_pkg::MODE_ONE_TO_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            map_mode_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
